// ===== src/blpg_pkg.sv =====
package blpg_pkg;

   // Fixed widths of the stream fields.
   localparam int FIELD_COORD_W = 12;
   localparam int COLOR_W       = 32;
   localparam int OFFSET_W      = 24;
   localparam int REG_W         = 13;
   localparam int REQ_DATA_W    = 80;
   localparam int RSP_DATA_W    = 80;
   localparam int CSR_ADDR_W    = 1;

   // Command codes carried on req_tuser.
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   // Register reset values.
   localparam logic [REG_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
   localparam logic [REG_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

   // Depth of the command queue between the front and back ends.
   localparam int CMD_QUEUE_DEPTH = 2;

   // One decoded command as it waits in the queue.
   typedef struct packed {
      logic                     opcode;
      logic [FIELD_COORD_W-1:0] x_start;
      logic [FIELD_COORD_W-1:0] y_start;
      logic [FIELD_COORD_W-1:0] x_end;
      logic [FIELD_COORD_W-1:0] y_end;
      logic [COLOR_W-1:0]       color;
   } cmd_type;

endpackage

// ===== src/bresenham_line_pixel_generator.sv =====
// Bresenham line pixel generator.
// The req_ stream carries commands. A start transaction (req_tuser low) loads
// both endpoints and the line color and produces no output; it is dropped
// when frame_width is zero. A step transaction (req_tuser high) produces the
// next pixel of the line on the rsp_ stream; a step with no line in progress
// produces nothing. rsp_tlast marks the pixel at the second endpoint, after
// which the engine is idle. A start during a line replaces that line.
// rsp_tuser is the visible flag: when low the pixel is outside
// frame_width x frame_height and must not be written.
// Throughput is one transaction per cycle while the receiver keeps up.
// The Bresenham update and the row multiply run at the head of the command
// queue into the first stage; the output register completes the offset add.
// When the receiver stalls the two result stages fill, then the two-entry
// command queue fills and req_tready drops.
// Reset clears the queue, the pipeline and the line state, and sets the
// frame size to 640 x 480. The csr_ port is to be written only while
// idle, by the user; the block itself does not enforce this.
module bresenham_line_pixel_generator
   import blpg_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // x_start, y_start, x_end, y_end, color
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pixel_x, pixel_y, word_offset, pixel_color
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // visible
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata
);

   logic [REG_W-1:0]         frame_width_ff, frame_width_in;
   logic [REG_W-1:0]         frame_height_ff, frame_height_in;
   logic                     cmd_valid;
   cmd_type                  cmd;
   logic                     cmd_pop;
   logic [FIELD_COORD_W-1:0] pixel_x;
   logic [FIELD_COORD_W-1:0] pixel_y;
   logic [OFFSET_W-1:0]      word_offset;
   logic [COLOR_W-1:0]       pixel_color;

   // Frame size registers.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_FRAME_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Front end: decode and queue commands.
   blpg_cmd_queue u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // Back end: line stepping and pixel output.
   blpg_line_engine #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .pixel_x      (pixel_x),
      .pixel_y      (pixel_y),
      .word_offset  (word_offset),
      .visible      (rsp_tuser),
      .pixel_color  (pixel_color),
      .last         (rsp_tlast)
   );

   assign rsp_tdata = {pixel_color, word_offset, pixel_y, pixel_x};

endmodule

// ===== src/blpg_cmd_queue.sv =====
module blpg_cmd_queue
   import blpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  cmd_valid,
   output cmd_type               cmd,
   input  logic                  cmd_pop
);

   localparam int PTR_W   = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type              mem_ff [CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   cmd_type              req_cmd;
   logic                 push;
   logic                 pop;

   // Split the incoming transaction into its command fields.
   always_comb begin
      req_cmd.opcode  = req_tuser;
      req_cmd.x_start = req_tdata[11:0];
      req_cmd.y_start = req_tdata[23:12];
      req_cmd.x_end   = req_tdata[35:24];
      req_cmd.y_end   = req_tdata[47:36];
      req_cmd.color   = req_tdata[79:48];
   end

   assign req_tready = (count_ff != COUNT_W'(CMD_QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = mem_ff[rd_ptr_ff];

   // Pointer and fill-count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_cmd;
      end
   end

endmodule

// ===== src/blpg_line_engine.sv =====
module blpg_line_engine
   import blpg_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [REG_W-1:0]         frame_width,
   input  logic [REG_W-1:0]         frame_height,
   input  logic                     cmd_valid,
   input  cmd_type                  cmd,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [FIELD_COORD_W-1:0] pixel_x,
   output logic [FIELD_COORD_W-1:0] pixel_y,
   output logic [OFFSET_W-1:0]      word_offset,
   output logic                     visible,
   output logic [COLOR_W-1:0]       pixel_color,
   output logic                     last
);

   localparam int ERR_W  = COORD_BITS + 2;
   localparam int E2_W   = COORD_BITS + 3;
   localparam int CMP_W  = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
   localparam int PROD_W = COORD_BITS + REG_W;

   // Line state.
   logic [COORD_BITS-1:0]   cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]   cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]   stop_x_ff, stop_x_in;
   logic [COORD_BITS-1:0]   stop_y_ff, stop_y_in;
   logic [COORD_BITS-1:0]   span_x_ff, span_x_in;
   logic [COORD_BITS-1:0]   span_y_ff, span_y_in;
   logic                    dir_x_neg_ff, dir_x_neg_in;
   logic                    dir_y_neg_ff, dir_y_neg_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic                    busy_ff, busy_in;
   logic [COLOR_W-1:0]      color_ff, color_in;

   // First pipeline stage: pixel coordinates and row product.
   logic                     a_valid_ff, a_valid_in;
   logic [FIELD_COORD_W-1:0] a_x_ff, a_y_ff;
   logic [OFFSET_W-1:0]      a_prod_ff;
   logic [OFFSET_W-1:0]      a_col_ff;
   logic                     a_vis_ff;
   logic                     a_last_ff;
   logic [COLOR_W-1:0]       a_color_ff;

   // Output register.
   logic                     b_valid_ff, b_valid_in;
   logic [FIELD_COORD_W-1:0] b_x_ff, b_y_ff;
   logic [OFFSET_W-1:0]      b_offset_ff;
   logic                     b_vis_ff;
   logic                     b_last_ff;
   logic [COLOR_W-1:0]       b_color_ff;

   logic                  b_ready;
   logic                  issue_ok;
   logic                  is_start;
   logic                  do_load;
   logic                  do_step;
   logic                  at_end;
   logic [COORD_BITS-1:0] x0, y0, x1, y1;
   logic signed [E2_W-1:0] e2, sx_ext, sy_ext, err_wide;
   logic                  move_x, move_y;
   logic [PROD_W-1:0]     prod;
   logic                  vis;

   // Handshake between the command head, the two stages and the receiver.
   assign b_ready  = !b_valid_ff || rsp_ready;
   assign issue_ok = !a_valid_ff || b_ready;
   assign is_start = (cmd.opcode == OP_START);
   assign cmd_pop  = cmd_valid && (is_start || !busy_ff || issue_ok);
   assign do_load  = cmd_pop && is_start && (frame_width != '0);
   assign do_step  = cmd_pop && !is_start && busy_ff;

   // Endpoints at the internal coordinate width.
   assign x0 = COORD_BITS'(cmd.x_start);
   assign y0 = COORD_BITS'(cmd.y_start);
   assign x1 = COORD_BITS'(cmd.x_end);
   assign y1 = COORD_BITS'(cmd.y_end);

   // Bresenham decision: doubled error against both spans.
   assign at_end = (cur_x_ff == stop_x_ff) && (cur_y_ff == stop_y_ff);
   assign sx_ext = $signed({3'b000, span_x_ff});
   assign sy_ext = $signed({3'b000, span_y_ff});
   assign e2     = $signed({err_ff, 1'b0});
   assign move_x = e2 > -sy_ext;
   assign move_y = e2 < sx_ext;

   always_comb begin
      err_wide = E2_W'(err_ff);
      if (move_x) begin
         err_wide = err_wide - sy_ext;
      end
      if (move_y) begin
         err_wide = err_wide + sx_ext;
      end
   end

   // Pixel address terms and clipping.
   assign prod = PROD_W'(cur_y_ff) * PROD_W'(frame_width);
   assign vis  = (CMP_W'(cur_x_ff) < CMP_W'(frame_width)) &&
                 (CMP_W'(cur_y_ff) < CMP_W'(frame_height));

   // Next line state.
   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      stop_x_in    = stop_x_ff;
      stop_y_in    = stop_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      err_in       = err_ff;
      busy_in      = busy_ff;
      color_in     = color_ff;
      if (do_load) begin
         cur_x_in     = x0;
         cur_y_in     = y0;
         stop_x_in    = x1;
         stop_y_in    = y1;
         span_x_in    = (x1 > x0) ? x1 - x0 : x0 - x1;
         span_y_in    = (y1 > y0) ? y1 - y0 : y0 - y1;
         dir_x_neg_in = !(x0 < x1);
         dir_y_neg_in = !(y0 < y1);
         err_in       = $signed({2'b00, span_x_in}) - $signed({2'b00, span_y_in});
         color_in     = cmd.color;
         busy_in      = 1'b1;
      end else if (do_step) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            err_in = err_wide[ERR_W-1:0];
            if (move_x) begin
               cur_x_in = dir_x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
            if (move_y) begin
               cur_y_in = dir_y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         stop_x_ff    <= '0;
         stop_y_ff    <= '0;
         span_x_ff    <= '0;
         span_y_ff    <= '0;
         dir_x_neg_ff <= 1'b0;
         dir_y_neg_ff <= 1'b0;
         err_ff       <= '0;
         busy_ff      <= 1'b0;
         color_ff     <= '0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         stop_x_ff    <= stop_x_in;
         stop_y_ff    <= stop_y_in;
         span_x_ff    <= span_x_in;
         span_y_ff    <= span_y_in;
         dir_x_neg_ff <= dir_x_neg_in;
         dir_y_neg_ff <= dir_y_neg_in;
         err_ff       <= err_in;
         busy_ff      <= busy_in;
         color_ff     <= color_in;
      end
   end

   // Stage valid flags advance only when the next stage has room.
   always_comb begin
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      if (issue_ok) begin
         a_valid_in = do_step;
      end
      if (b_ready) begin
         b_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // First stage captures the current pixel as the step is taken.
   always_ff @(posedge clock) begin
      if (do_step) begin
         a_x_ff     <= FIELD_COORD_W'(cur_x_ff);
         a_y_ff     <= FIELD_COORD_W'(cur_y_ff);
         a_prod_ff  <= OFFSET_W'(prod);
         a_col_ff   <= OFFSET_W'(cur_x_ff);
         a_vis_ff   <= vis;
         a_last_ff  <= at_end;
         a_color_ff <= color_ff;
      end
   end

   // Output register completes the word offset.
   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_x_ff      <= a_x_ff;
         b_y_ff      <= a_y_ff;
         b_offset_ff <= a_prod_ff + a_col_ff;
         b_vis_ff    <= a_vis_ff;
         b_last_ff   <= a_last_ff;
         b_color_ff  <= a_color_ff;
      end
   end

   assign rsp_valid   = b_valid_ff;
   assign pixel_x     = b_x_ff;
   assign pixel_y     = b_y_ff;
   assign word_offset = b_offset_ff;
   assign visible     = b_vis_ff;
   assign pixel_color = b_color_ff;
   assign last        = b_last_ff;

endmodule

// ===== verif/blpg_checker.sv =====
`timescale 1ns / 1ps

// Watches the command, pixel and register channels of the line engine,
// traces every line step by step on its own, and compares each pixel that
// leaves the block with the oldest pixel still owed.
module blpg_checker
   import blpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata,
   output int                    mismatches,
   output int                    outstanding,
   output int                    pixels_checked
);

   typedef struct {
      logic [FIELD_COORD_W-1:0] px;
      logic [FIELD_COORD_W-1:0] py;
      logic [OFFSET_W-1:0]      offset;
      logic                     vis;
      logic [COLOR_W-1:0]       color;
      logic                     tail;
   } pixel_type;

   // Pixels owed by the block, oldest first.
   pixel_type owed_pixels[$];

   // Frame size as last written.
   logic [REG_W-1:0] frame_w = RESET_FRAME_WIDTH;
   logic [REG_W-1:0] frame_h = RESET_FRAME_HEIGHT;

   // Line state of the traced engine.
   logic [FIELD_COORD_W-1:0] pos_x, pos_y, end_x, end_y, run_x, run_y;
   logic                     x_down, y_down;
   int                       err_term;
   logic                     drawing;
   logic [COLOR_W-1:0]       ink;

   initial begin
      mismatches     = 0;
      pixels_checked = 0;
      outstanding    = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic clear_line();
      pos_x    = '0;
      pos_y    = '0;
      end_x    = '0;
      end_y    = '0;
      run_x    = '0;
      run_y    = '0;
      x_down   = 1'b0;
      y_down   = 1'b0;
      err_term = 0;
      drawing  = 1'b0;
      ink      = '0;
   endtask

   // Load a new line from a start transaction; dropped while the width is zero.
   task automatic begin_line(input logic [REQ_DATA_W-1:0] d);
      logic [FIELD_COORD_W-1:0] x0, y0, x1, y1;
      x0 = d[11:0];
      y0 = d[23:12];
      x1 = d[35:24];
      y1 = d[47:36];
      if (frame_w == '0)
         return;
      pos_x    = x0;
      pos_y    = y0;
      end_x    = x1;
      end_y    = y1;
      run_x    = (x1 > x0) ? x1 - x0 : x0 - x1;
      run_y    = (y1 > y0) ? y1 - y0 : y0 - y1;
      x_down   = !(x0 < x1);
      y_down   = !(y0 < y1);
      err_term = int'(run_x) - int'(run_y);
      ink      = d[79:48];
      drawing  = 1'b1;
   endtask

   // Emit the current pixel of the line and advance one Bresenham step.
   task automatic advance_line();
      pixel_type   p;
      logic [31:0] linear;
      int          e2;
      if (!drawing)
         return;
      linear   = pos_y * frame_w + pos_x;
      p.px     = pos_x;
      p.py     = pos_y;
      p.offset = linear[OFFSET_W-1:0];
      p.vis    = (pos_x < frame_w) && (pos_y < frame_h);
      p.color  = ink;
      p.tail   = (pos_x == end_x) && (pos_y == end_y);
      owed_pixels.push_back(p);
      if (p.tail) begin
         drawing = 1'b0;
      end else begin
         e2 = err_term * 2;
         if (e2 > -int'(run_y)) begin
            err_term -= int'(run_y);
            pos_x = x_down ? pos_x - 1'b1 : pos_x + 1'b1;
         end
         if (e2 < int'(run_x)) begin
            err_term += int'(run_x);
            pos_y = y_down ? pos_y - 1'b1 : pos_y + 1'b1;
         end
      end
   endtask

   initial clear_line();

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         owed_pixels.delete();
         clear_line();
         frame_w = RESET_FRAME_WIDTH;
         frame_h = RESET_FRAME_HEIGHT;
      end else begin
         // Compare a delivered pixel with the oldest one owed.
         if (rsp_tvalid && rsp_tready) begin
            if (owed_pixels.size() == 0) begin
               report_mismatch("pixel with none owed", rsp_tdata[11:0], '0);
            end else begin
               want = owed_pixels.pop_front();
               pixels_checked++;
               if (rsp_tdata[11:0] !== want.px)
                  report_mismatch("pixel_x", rsp_tdata[11:0], want.px);
               if (rsp_tdata[23:12] !== want.py)
                  report_mismatch("pixel_y", rsp_tdata[23:12], want.py);
               if (rsp_tdata[47:24] !== want.offset)
                  report_mismatch("word_offset", rsp_tdata[47:24], want.offset);
               if (rsp_tdata[79:48] !== want.color)
                  report_mismatch("pixel_color", rsp_tdata[79:48], want.color);
               if (rsp_tuser !== want.vis)
                  report_mismatch("visible", rsp_tuser, want.vis);
               if (rsp_tlast !== want.tail)
                  report_mismatch("last", rsp_tlast, want.tail);
            end
         end
         // Trace each accepted command transaction.
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_START)
               begin_line(req_tdata);
            else
               advance_line();
         end
         // Register writes take effect for later commands.
         if (csr_we) begin
            if (csr_addr == REG_FRAME_WIDTH)
               frame_w = csr_wdata;
            else if (csr_addr == REG_FRAME_HEIGHT)
               frame_h = csr_wdata;
         end
      end
      outstanding <= owed_pixels.size();
   end

endmodule

// ===== verif/tb_bresenham_line_pixel_generator.sv =====
`timescale 1ns / 1ps

module tb_bresenham_line_pixel_generator
   import blpg_pkg::*;
();

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1700;
   localparam int HOLD_CYCLES  = 150;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [REG_W-1:0]      csr_wdata  = '0;

   int mismatches, outstanding, pixels_checked;
   int items_sent    = 0;
   int frame_writes  = 0;
   int idle_cycles   = 0;
   int cfg_w         = 640;
   bit hold_receiver = 1'b0;
   bit sender_burst  = 1'b0;
   bit receiver_free = 1'b0;

   always #1 clock = ~clock;

   bresenham_line_pixel_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   blpg_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .pixels_checked (pixels_checked)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // Pixel receiver: random stalls, free-running stretches, and one long
   // hold-off on request so that the pipeline and command queue fill up.
   initial begin
      int run_left;
      bit ready_now;
      run_left  = 0;
      ready_now = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            run_left      = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (run_left == 0) begin
               if (receiver_free) begin
                  ready_now = 1'b1;
                  run_left  = $urandom_range(1, 20);
               end else begin
                  ready_now = ($urandom_range(0, 3) != 0);
                  run_left  = ready_now ? $urandom_range(1, 8) : gap_length();
               end
            end
            run_left--;
            rsp_tready <= ready_now;
         end
      end
   end

   // Watchdog: count cycles in which no transaction completes on either stream.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("[bresenham_line_pixel_generator] ERROR");
      $finish;
   end

   // Offer one command transaction and hold it until the block takes it.
   task automatic offer(input logic op, input logic [31:0] xs, input logic [31:0] ys,
                        input logic [31:0] xe, input logic [31:0] ye,
                        input logic [31:0] c);
      req_tuser  <= op;
      req_tdata  <= {c, ye[11:0], xe[11:0], ys[11:0], xs[11:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      items_sent++;
   endtask

   task automatic sender_gap();
      int n;
      n = (sender_burst || $urandom_range(0, 2) != 0) ? 0 : gap_length();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_start(input int x0, input int y0, input int x1, input int y1,
                             input logic [31:0] c);
      offer(OP_START, x0, y0, x1, y1, c);
      sender_gap();
   endtask

   // Step commands carry random payload bits, which the block ignores.
   task automatic send_steps(input int n);
      repeat (n) begin
         offer(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
         sender_gap();
      end
   endtask

   // Stop sending and wait until every owed pixel has been delivered.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both frame registers on consecutive cycles.
   task automatic set_frame(input int w, input int h);
      csr_we    <= 1'b1;
      csr_addr  <= REG_FRAME_WIDTH;
      csr_wdata <= w[REG_W-1:0];
      @(posedge clock);
      csr_addr  <= REG_FRAME_HEIGHT;
      csr_wdata <= h[REG_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_w = w;
      frame_writes++;
   endtask

   task automatic random_frame();
      case ($urandom_range(0, 9))
         0:       set_frame(0, $urandom_range(0, 4096));
         1:       set_frame(4096, 4096);
         2:       set_frame(1, $urandom_range(0, 1));
         3:       set_frame(640, 480);
         4:       set_frame($urandom_range(1, 4096), 0);
         default: set_frame($urandom_range(1, 4096), $urandom_range(1, 4096));
      endcase
   endtask

   // Either anywhere on the coordinate range or near the visible frame.
   function automatic int pick_coord();
      if ($urandom_range(0, 1) == 0)
         return $urandom_range(0, 4095);
      return $urandom_range(0, (cfg_w + 4 > 4095) ? 4095 : cfg_w + 4);
   endfunction

   function automatic int nearby(input int v, input int reach);
      int r;
      r = v + $urandom_range(0, 2 * reach) - reach;
      if (r < 0)
         r = 0;
      if (r > 4095)
         r = 4095;
      return r;
   endfunction

   // One random line: mostly drawn to its end, sometimes cut short by a new
   // start, overrun with idle steps, mixed with noise, or reconfigured midway.
   task automatic random_line();
      int x0, y0, x1, y1, reach, n, kind, half;
      case ($urandom_range(0, 49))
         0:       reach = 400;
         1, 2, 3: reach = 64;
         default: reach = 12;
      endcase
      x0 = pick_coord();
      y0 = pick_coord();
      x1 = nearby(x0, reach);
      y1 = nearby(y0, reach);
      n  = ((x1 > x0 ? x1 - x0 : x0 - x1) > (y1 > y0 ? y1 - y0 : y0 - y1) ?
            (x1 > x0 ? x1 - x0 : x0 - x1) : (y1 > y0 ? y1 - y0 : y0 - y1)) + 1;
      send_start(x0, y0, x1, y1, $urandom);
      kind = $urandom_range(0, 11);
      case (kind)
         0: send_steps($urandom_range(0, n - 1));
         1: send_steps(n + $urandom_range(1, 3));
         2: begin
            repeat ($urandom_range(1, 3)) begin
               offer(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                     $urandom, $urandom);
               sender_gap();
            end
            send_steps(n);
         end
         3: begin
            half = n / 2;
            send_steps(half);
            settle();
            random_frame();
            send_steps(n - half);
         end
         default: send_steps(n);
      endcase
   endtask

   initial begin
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: a step with no line, a single-pixel line, a steep line,
      // a restart in mid-line, a zero width that drops a start while the old
      // line carries on, and a line at the far corner of the largest frame.
      send_steps(1);
      send_start(5, 5, 5, 5, 32'hFFFF_FFFF);
      send_steps(1);
      send_start(0, 0, 1, 3, 32'hA5A5_5A5A);
      send_steps(4);
      send_start(10, 10, 20, 12, 32'h0000_0000);
      send_steps(2);
      send_start(100, 50, 98, 50, 32'h1234_5678);
      send_steps(3);
      send_start(1, 1, 3, 1, 32'h8000_0001);
      send_steps(1);
      settle();
      set_frame(0, 480);
      send_start(7, 7, 7, 7, 32'h5555_AAAA);
      send_steps(2);
      settle();
      set_frame(4096, 4096);
      send_start(4095, 4095, 4094, 4093, 32'hC0FF_EE00);
      send_steps(3);

      // Long hold-off on the pixel side while commands keep coming.
      settle();
      set_frame(640, 480);
      sender_burst  = 1'b1;
      hold_receiver = 1'b1;
      send_start(0, 0, 300, 100, $urandom);
      send_steps(60);
      settle();

      // Random lines in phases, each with its own frame size and idling style.
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         settle();
         random_frame();
         sender_burst  = ($urandom_range(0, 3) == 0);
         receiver_free = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 6)) random_line();
      end

      settle();
      $display("Sent %0d command transactions over %0d frame size settings;",
               items_sent, frame_writes);
      $display("checked %0d pixels, including restarts, clipping and idle steps.",
               pixels_checked);
      if (mismatches == 0)
         $display("[bresenham_line_pixel_generator] OK");
      else
         $display("[bresenham_line_pixel_generator] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
src/blpg_pkg.sv
src/blpg_cmd_queue.sv
src/blpg_line_engine.sv
src/bresenham_line_pixel_generator.sv
verif/blpg_checker.sv
verif/tb_bresenham_line_pixel_generator.sv
